/* src/sclt_pkg.sv */
// Shared constants and types of the sector cache tag unit.
package sclt_pkg;

  localparam int unsigned WAYS         = 4;
  localparam int unsigned SECTOR_COUNT = 1024;
  localparam int unsigned SECTOR_W     = 10;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned WAY_W        = $clog2(WAYS);

  // Every sector code is legal when the sector count fills the field.
  localparam bit SECTOR_FULL = (SECTOR_COUNT >= (2 ** SECTOR_W));

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [SECTOR_W-1:0] sector;
    logic [STAMP_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             fetch;
    logic [WAYS-1:0]  cleared;
  } rsp_t;

endpackage

/* src/sclt_if.sv */
// Request and response channel interfaces of the sector cache tag unit.
interface sclt_req_if;
  logic                          valid;
  logic                          ready;
  sclt_pkg::action_e             action;
  logic [sclt_pkg::SECTOR_W-1:0] sector;
  logic [sclt_pkg::STAMP_W-1:0]  now;

  modport source (output valid, output action, output sector, output now, input ready);
  modport sink   (input valid, input action, input sector, input now, output ready);
endinterface

interface sclt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [sclt_pkg::WAY_W-1:0] way;
  logic                       fetch;
  logic [sclt_pkg::WAYS-1:0]  cleared;

  modport source (output valid, output hit, output way, output fetch, output cleared,
                  input ready);
  modport sink   (input valid, input hit, input way, input fetch, input cleared,
                  output ready);
endinterface

/* src/sector_cache_lru_tags_unit.sv */
// Tag, valid and stamp store of a four-way fully associative sector cache with LRU refill.
//
// Each request item is taken into an input register, looked up against all ways and its
// result item written to an output register. A result is presented from the output
// register until the response side takes it. One item is accepted every clock cycle while
// the response side keeps taking results. The tag compare, invalid-way search and oldest
// stamp search between the two registers are combinational, which allows that rate. The way
// state is updated as the result is registered, so the following item already sees it.
// A read hit restamps the way. A read miss fills the lowest invalid way, or else the oldest
// one (lowest way on equal stamps), and raises fetch. A write invalidates every valid way
// holding the sector and reports the mask in cleared.
module sector_cache_lru_tags_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  sclt_req_if.sink        req_i,
  sclt_rsp_if.source      rsp_o
);

  localparam int unsigned WAYS     = sclt_pkg::WAYS;
  localparam int unsigned WAY_W    = sclt_pkg::WAY_W;
  localparam int unsigned SECTOR_W = sclt_pkg::SECTOR_W;
  localparam int unsigned STAMP_W  = sclt_pkg::STAMP_W;

  logic                in_vld_q;
  sclt_pkg::req_t      in_q;
  logic                out_vld_q;
  sclt_pkg::rsp_t      out_q, out_d;

  logic [WAYS-1:0]     valid_q, valid_d;
  logic [SECTOR_W-1:0] tag_q   [WAYS];
  logic [STAMP_W-1:0]  stamp_q [WAYS];

  logic                advance;
  logic [WAYS-1:0]     match;
  logic [WAY_W-1:0]    hit_way, free_way, old_way, victim;
  logic                any_free;
  logic                in_range;
  logic                wr_tag;
  logic [WAY_W-1:0]    wr_way;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  assign in_range = sclt_pkg::SECTOR_FULL ||
                    (in_q.sector < sclt_pkg::SECTOR_COUNT[SECTOR_W-1:0]);

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    any_free = 1'b0;
    for (int k = 0; k < WAYS; k++) begin
      match[k] = valid_q[k] && (tag_q[k] == in_q.sector);
    end
    // Walk downwards so the lowest matching or free way wins.
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_way = WAY_W'(k);
      end
      if (!valid_q[k]) begin
        free_way = WAY_W'(k);
        any_free = 1'b1;
      end
    end
    // Strictly smaller stamp replaces, so ties keep the lower way.
    old_way = '0;
    for (int k = 1; k < WAYS; k++) begin
      if (stamp_q[k] < stamp_q[old_way]) begin
        old_way = WAY_W'(k);
      end
    end
    victim = any_free ? free_way : old_way;
  end

  always_comb begin
    out_d   = '0;
    valid_d = valid_q;
    wr_tag  = 1'b0;
    wr_way  = hit_way;
    if (in_range) begin
      unique case (in_q.action)
        sclt_pkg::ACT_WRITE: begin
          out_d.cleared = match;
          valid_d       = valid_q & ~match;
        end
        sclt_pkg::ACT_READ: begin
          if (|match) begin
            out_d.hit = 1'b1;
            out_d.way = hit_way;
          end else begin
            out_d.fetch     = 1'b1;
            out_d.way       = victim;
            wr_tag          = 1'b1;
            wr_way          = victim;
            valid_d[victim] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        valid_q   <= valid_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: tags and stamps are only read behind a valid bit.
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.action <= req_i.action;
      in_q.sector <= req_i.sector;
      in_q.now    <= req_i.now;
    end
    if (advance) begin
      out_q <= out_d;
      if (in_range && (in_q.action == sclt_pkg::ACT_READ)) begin
        stamp_q[wr_way] <= in_q.now;
        if (wr_tag) begin
          tag_q[wr_way] <= in_q.sector;
        end
      end
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.hit     = out_q.hit;
  assign rsp_o.way     = out_q.way;
  assign rsp_o.fetch   = out_q.fetch;
  assign rsp_o.cleared = out_q.cleared;

endmodule

/* src/sclt_checker.sv */
// Port-level assertions for the sector cache tag unit, bound to its top level.
module sclt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_hit_i,
  input logic [sclt_pkg::WAY_W-1:0] rsp_way_i,
  input logic                       rsp_fetch_i,
  input logic [sclt_pkg::WAYS-1:0]  rsp_cleared_i
);

  // A read either hits or fetches, never both.
  a_hit_xor_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_fetch_i))
    else $error("result item reports both hit and fetch");

  // A write result carries only the cleared mask.
  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_cleared_i != '0)) |->
      (!rsp_hit_i && !rsp_fetch_i && (rsp_way_i == '0)))
    else $error("write result item carries read fields");

  // Hold a stalled result item.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_way_i) &&
       $stable(rsp_fetch_i) && $stable(rsp_cleared_i)))
    else $error("stalled result item changed");

endmodule

bind sector_cache_lru_tags_unit sclt_checker u_sclt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_hit_i     (rsp_o.hit),
  .rsp_way_i     (rsp_o.way),
  .rsp_fetch_i   (rsp_o.fetch),
  .rsp_cleared_i (rsp_o.cleared)
);
